>>> src/spat_pkg.sv
// ----------------------------------------------------------------------------
// spat_pkg
// Shared types and constants of the slot pool allocator with tag map.
// ----------------------------------------------------------------------------
package spat_pkg;

  localparam int CMD_W      = 3;
  localparam int SLOT_IDX_W = 6;
  localparam int TAG_IN_W   = 16;
  localparam int COUNT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC       = 3'd0,
    CMD_RELEASE     = 3'd1,
    CMD_LINK        = 3'd2,
    CMD_UNLINK      = 3'd3,
    CMD_FIND        = 3'd4,
    CMD_ALLOC_LINK  = 3'd5,
    CMD_RELEASE_TAG = 3'd6
  } cmd_t;

  // Free stack requests from the sequencer.
  typedef struct packed {
    logic rd_en;       // read the top entry
    logic pop_commit;  // retire the entry read in the previous cycle
    logic push_en;     // push a slot
  } stk_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

  // Tag scan requests from the sequencer.
  typedef struct packed {
    logic start;  // rewind the scan pointer
    logic run;    // advance the scan
    logic wr_en;  // write a tag entry
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } scan_sts_t;

endpackage

>>> src/slot_pool_allocator_with_tag_map.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_tag_map
// Slot pool with a free-list stack, per-slot in-use and tag-valid bits and a
// tag map searched by a sequential scan.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_stall   cmd, target_slot, entity_tag
//   out      out_valid / out_stall result_slot, ok, busy_count
//
// One command is taken at a time; in_stall is high until its result is in
// the output register. Link and unlink pass through S_LINK, release through
// S_PUSH and an unused code straight to S_DONE; alloc and alloc_and_link pass
// through S_POP and S_POPW (S_POP only on an empty pool), since the free
// stack memory read is registered. Find stays in S_SCAN while the tag scan
// compares one slot a cycle; release_by_tag adds S_PUSH. Synchronous reset
// needs no clearing pass. A stalled result holds; the next command is accepted
// while it waits and completes as soon as the output register frees up.
// ----------------------------------------------------------------------------
module slot_pool_allocator_with_tag_map #(
  parameter int NUM_SLOTS = 64,
  parameter int TAG_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spat_pkg::CMD_W-1:0]        cmd,
  input  logic [spat_pkg::SLOT_IDX_W-1:0]   target_slot,
  input  logic [spat_pkg::TAG_IN_W-1:0]     entity_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spat_pkg::SLOT_IDX_W-1:0]   result_slot,
  output logic                              ok,
  output logic [spat_pkg::COUNT_W-1:0]      busy_count
);
  import spat_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_POPW = 7'b0000100,
    S_LINK = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_PUSH = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                state;
  cmd_t                  cmd_in;
  cmd_t                  cmd_q;
  logic [SLOT_IDX_W-1:0] idx_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [SW-1:0]         cur_slot;
  logic [SW-1:0]         res_slot;
  logic                  res_ok;
  logic [NUM_SLOTS-1:0]  in_use;
  logic [NUM_SLOTS-1:0]  tag_valid;
  logic [CW-1:0]         used_count;

  logic                  accept;
  logic [SW-1:0]         idx_slot;
  logic                  idx_ok;
  logic                  link_ok;
  logic                  push_ok;

  stk_ctl_t              stk_ctl;
  stk_sts_t              stk_sts;
  logic [SW-1:0]         pop_slot;
  scan_ctl_t             scan_ctl;
  scan_sts_t             scan_sts;
  logic [SW-1:0]         hit_slot;
  logic [SW-1:0]         tag_wr_addr;

  assign cmd_in   = cmd_t'(cmd);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    idx_slot = SW'(idx_q);
    idx_ok   = (int'(idx_q) < NUM_SLOTS);
    link_ok  = idx_ok && in_use[idx_slot];
    // Release by tag pushes a slot that the scan found in use.
    push_ok  = ((cmd_q != CMD_RELEASE) || idx_ok) && in_use[cur_slot] && !stk_sts.full;

    stk_ctl.rd_en      = (state == S_POP) && !stk_sts.empty;
    stk_ctl.pop_commit = (state == S_POPW);
    stk_ctl.push_en    = (state == S_PUSH) && push_ok;

    scan_ctl.start = accept && ((cmd_in == CMD_FIND) || (cmd_in == CMD_RELEASE_TAG));
    scan_ctl.run   = (state == S_SCAN);
    scan_ctl.wr_en = ((state == S_LINK) && link_ok && (cmd_q == CMD_LINK)) ||
                     ((state == S_POPW) && (cmd_q == CMD_ALLOC_LINK));
    tag_wr_addr    = (state == S_POPW) ? pop_slot : idx_slot;
  end

  spat_free_stack #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_slot (cur_slot),
    .pop_slot  (pop_slot),
    .sts       (stk_sts)
  );

  spat_tag_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .TAG_BITS  (TAG_BITS)
  ) u_tag_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .wr_addr  (tag_wr_addr),
    .wr_tag   (tag_q),
    .key      (tag_q),
    .live     (in_use & tag_valid),
    .sts      (scan_sts),
    .hit_slot (hit_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_use     <= '0;
      tag_valid  <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A beat leaving while a new one is loaded is handled in S_DONE.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_in;
            idx_q    <= target_slot;
            tag_q    <= TAG_BITS'(entity_tag);
            cur_slot <= SW'(target_slot);
            res_ok   <= 1'b0;
            res_slot <= '0;
            case (cmd_in)
              CMD_ALLOC, CMD_ALLOC_LINK: state <= S_POP;
              CMD_RELEASE:               state <= S_PUSH;
              CMD_LINK, CMD_UNLINK:      state <= S_LINK;
              CMD_FIND, CMD_RELEASE_TAG: state <= S_SCAN;
              default:                   state <= S_DONE;
            endcase
          end
        end
        S_POP: begin
          state <= stk_sts.empty ? S_DONE : S_POPW;
        end
        S_POPW: begin
          in_use[pop_slot]    <= 1'b1;
          tag_valid[pop_slot] <= (cmd_q == CMD_ALLOC_LINK);
          used_count          <= used_count + CW'(1);
          res_ok              <= 1'b1;
          res_slot            <= pop_slot;
          state               <= S_DONE;
        end
        S_LINK: begin
          if (link_ok) begin
            tag_valid[idx_slot] <= (cmd_q == CMD_LINK);
            res_ok              <= 1'b1;
            res_slot            <= idx_slot;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (scan_sts.hit) begin
            if (cmd_q == CMD_FIND) begin
              res_ok   <= 1'b1;
              res_slot <= hit_slot;
              state    <= S_DONE;
            end else begin
              cur_slot <= hit_slot;
              state    <= S_PUSH;
            end
          end else if (scan_sts.miss) begin
            state <= S_DONE;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            in_use[cur_slot]    <= 1'b0;
            tag_valid[cur_slot] <= 1'b0;
            if (used_count != '0) begin
              used_count <= used_count - CW'(1);
            end
            res_ok   <= 1'b1;
            res_slot <= cur_slot;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            result_slot <= res_ok ? SLOT_IDX_W'(res_slot) : '0;
            ok          <= res_ok;
            busy_count  <= COUNT_W'(used_count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/spat_free_stack.sv
// ----------------------------------------------------------------------------
// spat_free_stack
// Free-list stack of slot indexes in a memory with a registered read port.
// Entries below the low-water mark were never written and read as their
// reset value, so the stack needs no clearing pass.
// ----------------------------------------------------------------------------
module spat_free_stack #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spat_pkg::stk_ctl_t               ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]     push_slot,
  output logic [$clog2(NUM_SLOTS)-1:0]     pop_slot,
  output spat_pkg::stk_sts_t               sts
);
  import spat_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int DW = $clog2(NUM_SLOTS + 1);

  logic [SW-1:0] mem [NUM_SLOTS];
  logic [DW-1:0] depth;
  logic [DW-1:0] lwm;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] rd_addr_q;
  logic [SW-1:0] rd_data_q;
  logic          use_rst_q;

  assign rd_addr = SW'(depth - DW'(1));

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      use_rst_q <= (DW'(rd_addr) < lwm);
    end
    if (ctl.push_en) begin
      mem[depth[SW-1:0]] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= DW'(NUM_SLOTS);
      lwm   <= DW'(NUM_SLOTS);
    end else begin
      if (ctl.pop_commit) begin
        depth <= depth - DW'(1);
        if (use_rst_q) begin
          lwm <= DW'(rd_addr_q);
        end
      end else if (ctl.push_en) begin
        depth <= depth + DW'(1);
      end
    end
  end

  // At reset entry i holds NUM_SLOTS-1-i, so slot 0 sits on top.
  assign pop_slot  = use_rst_q ? (SW'(NUM_SLOTS - 1) - rd_addr_q) : rd_data_q;
  assign sts.empty = (depth == '0);
  assign sts.full  = (depth == DW'(NUM_SLOTS));

endmodule

>>> src/spat_tag_scan.sv
// ----------------------------------------------------------------------------
// spat_tag_scan
// Tag memory with one shared comparator that walks the slots from index 0
// upward, one slot a cycle, and reports the lowest live slot whose tag
// matches the key.
// ----------------------------------------------------------------------------
module spat_tag_scan #(
  parameter int NUM_SLOTS = 64,
  parameter int TAG_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spat_pkg::scan_ctl_t              ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]     wr_addr,
  input  logic [TAG_BITS-1:0]              wr_tag,
  input  logic [TAG_BITS-1:0]              key,
  input  logic [NUM_SLOTS-1:0]             live,
  output spat_pkg::scan_sts_t              sts,
  output logic [$clog2(NUM_SLOTS)-1:0]     hit_slot
);
  import spat_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);

  logic [TAG_BITS-1:0] mem [NUM_SLOTS];
  logic [PW-1:0]       ptr;
  logic                issue;
  logic                sv;
  logic                live_q;
  logic [SW-1:0]       sidx;
  logic [TAG_BITS-1:0] data_q;
  logic                hit;

  assign issue = ctl.run && (ptr != PW'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_tag;
    end
    if (issue) begin
      data_q <= mem[ptr[SW-1:0]];
      live_q <= live[ptr[SW-1:0]];
      sidx   <= ptr[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      sv  <= 1'b0;
    end else if (ctl.start) begin
      ptr <= '0;
      sv  <= 1'b0;
    end else if (ctl.run) begin
      sv <= issue;
      if (issue) begin
        ptr <= ptr + PW'(1);
      end
    end
  end

  // The compare stage works on the read registered in the cycle before; a miss is known once the
  // last slot has been compared.
  assign hit      = sv && live_q && (data_q == key);
  assign sts.hit  = hit;
  assign sts.miss = sv && !hit && (sidx == SW'(NUM_SLOTS - 1));
  assign hit_slot = sidx;

endmodule

>>> verif/slot_pool_checker.sv
// ----------------------------------------------------------------------------
// slot_pool_checker
// Watches both channels of the slot pool allocator, predicts every result
// from its own model of the free stack, in-use bits and tag map, and compares
// each output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_pool_checker #(
  parameter int NUM_SLOTS = 64,
  parameter int TAG_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [spat_pkg::CMD_W-1:0]      cmd,
  input  logic [spat_pkg::SLOT_IDX_W-1:0] target_slot,
  input  logic [spat_pkg::TAG_IN_W-1:0]   entity_tag,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [spat_pkg::SLOT_IDX_W-1:0] result_slot,
  input  logic                            ok,
  input  logic [spat_pkg::COUNT_W-1:0]    busy_count,
  output int                              fail_count,
  output int                              results_due,
  output int                              results_seen,
  output int                              ok_seen,
  output int                              peak_active,
  output int                              pool_empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import spat_pkg::*;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic                  ok;
    logic [COUNT_W-1:0]    count;
  } pool_reply_t;

  int                   free_stack [NUM_SLOTS];
  int                   free_depth;
  logic [NUM_SLOTS-1:0] in_use;
  logic [NUM_SLOTS-1:0] tag_linked;
  logic [TAG_BITS-1:0]  linked_tag [NUM_SLOTS];
  int                   used_count;
  pool_reply_t          replies_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns  slot pool mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic pop_free_slot(output int slot);
    slot = 0;
    if (free_depth == 0) return 1'b0;
    free_depth--;
    slot = free_stack[free_depth];
    used_count++;
    in_use[slot]     = 1'b1;
    tag_linked[slot] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic push_free_slot(input int slot);
    if (slot >= NUM_SLOTS || !in_use[slot] || free_depth >= NUM_SLOTS) return 1'b0;
    in_use[slot]     = 1'b0;
    tag_linked[slot] = 1'b0;
    free_stack[free_depth] = slot;
    free_depth++;
    if (used_count > 0) used_count--;
    return 1'b1;
  endfunction

  // The scan runs upward, so the lowest matching slot wins.
  function automatic logic lowest_tagged_slot(input logic [TAG_BITS-1:0] tag,
                                              output int slot);
    slot = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (in_use[i] && tag_linked[i] && linked_tag[i] == tag) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pool_reply_t apply_pool_command(input logic [CMD_W-1:0] op,
                                                     input int idx,
                                                     input logic [TAG_BITS-1:0] tag);
    int          slot;
    logic        hit;
    pool_reply_t reply;
    slot = 0;
    hit  = 1'b0;
    case (op)
      CMD_ALLOC: begin
        hit = pop_free_slot(slot);
      end
      CMD_RELEASE: begin
        hit  = push_free_slot(idx);
        slot = idx;
      end
      CMD_LINK, CMD_UNLINK: begin
        if (idx < NUM_SLOTS && in_use[idx]) begin
          if (op == CMD_LINK) begin
            linked_tag[idx] = tag;
            tag_linked[idx] = 1'b1;
          end else begin
            tag_linked[idx] = 1'b0;
          end
          hit  = 1'b1;
          slot = idx;
        end
      end
      CMD_FIND: begin
        hit = lowest_tagged_slot(tag, slot);
      end
      CMD_ALLOC_LINK: begin
        hit = pop_free_slot(slot);
        if (hit) begin
          linked_tag[slot] = tag;
          tag_linked[slot] = 1'b1;
        end
      end
      CMD_RELEASE_TAG: begin
        if (lowest_tagged_slot(tag, slot)) hit = push_free_slot(slot);
      end
      default: begin
      end
    endcase
    reply.slot  = hit ? SLOT_IDX_W'(slot) : '0;
    reply.ok    = hit;
    reply.count = COUNT_W'(used_count);
    return reply;
  endfunction

  // Results are compared before the new command is predicted, since a beat
  // leaving at this edge always belongs to an older command.
  always @(posedge clk) begin
    pool_reply_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        free_stack[i] = NUM_SLOTS - 1 - i;
      end
      free_depth = NUM_SLOTS;
      in_use     = '0;
      tag_linked = '0;
      used_count = 0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result beat with none pending (slot %0d ok %0b count %0d)",
                                    result_slot, ok, busy_count));
        end else begin
          want = replies_due.pop_front();
          if (result_slot !== want.slot)
            report_mismatch($sformatf("result_slot expected %0d, got %0d",
                                      want.slot, result_slot));
          if (ok !== want.ok)
            report_mismatch($sformatf("ok expected %0b, got %0b", want.ok, ok));
          if (busy_count !== want.count)
            report_mismatch($sformatf("busy_count expected %0d, got %0d",
                                      want.count, busy_count));
          if (want.ok) ok_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        if ((cmd == CMD_ALLOC || cmd == CMD_ALLOC_LINK) && free_depth == 0) pool_empty_hits++;
        replies_due.push_back(apply_pool_command(cmd, target_slot, entity_tag[TAG_BITS-1:0]));
        if (used_count > peak_active) peak_active = used_count;
      end
    end
    results_due = replies_due.size();
  end

endmodule

>>> verif/slot_pool_allocator_with_tag_map_tb.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_tag_map_tb
// Drives directed and random command beats into the slot pool, with bursty
// input traffic and a stalling receiver, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module slot_pool_allocator_with_tag_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spat_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int TAG_BITS  = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS   = 1550;
  localparam int PAUSE_EVERY    = 400;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = NUM_SLOTS + 16;
  localparam int RUN_LIMIT_NS   = 2_000_000;

  typedef enum int {FILL_UP, CHURN, DRAIN_DOWN} traffic_mix_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd;
  logic [SLOT_IDX_W-1:0] target_slot;
  logic [TAG_IN_W-1:0]   entity_tag;
  logic                  out_valid;
  logic                  out_stall;
  logic [SLOT_IDX_W-1:0] result_slot;
  logic                  ok;
  logic [COUNT_W-1:0]    busy_count;

  int fail_count;
  int results_due;
  int results_seen;
  int ok_seen;
  int peak_active;
  int pool_empty_hits;
  int beats_sent;
  int hot_tags [6];

  always #1 clk = ~clk;

  slot_pool_allocator_with_tag_map #(
    .NUM_SLOTS(NUM_SLOTS),
    .TAG_BITS (TAG_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .target_slot (target_slot),
    .entity_tag  (entity_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_slot (result_slot),
    .ok          (ok),
    .busy_count  (busy_count)
  );

  slot_pool_checker #(
    .NUM_SLOTS(NUM_SLOTS),
    .TAG_BITS (TAG_BITS)
  ) pool_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .target_slot    (target_slot),
    .entity_tag     (entity_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_slot    (result_slot),
    .ok             (ok),
    .busy_count     (busy_count),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .results_seen   (results_seen),
    .ok_seen        (ok_seen),
    .peak_active    (peak_active),
    .pool_empty_hits(pool_empty_hits)
  );

  // Offers one beat and returns once it has been taken.
  task automatic send_beat(input logic [CMD_W-1:0] c, input int idx, input int tag);
    @(negedge clk);
    in_valid    = 1'b1;
    cmd         = c;
    target_slot = idx[SLOT_IDX_W-1:0];
    entity_tag  = tag[TAG_IN_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    in_valid   = 1'b0;
    cmd        = CMD_W'($urandom);
    entity_tag = TAG_IN_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic pick_command(input traffic_mix_t mix, output logic [CMD_W-1:0] c,
                              output int idx, output int tag);
    int r;
    r = $urandom_range(99);
    case (mix)
      FILL_UP: begin
        if      (r < 45) c = CMD_ALLOC;
        else if (r < 70) c = CMD_ALLOC_LINK;
        else if (r < 78) c = CMD_LINK;
        else if (r < 84) c = CMD_FIND;
        else if (r < 90) c = CMD_RELEASE;
        else if (r < 94) c = CMD_UNLINK;
        else if (r < 98) c = CMD_RELEASE_TAG;
        else             c = CMD_UNUSED;
      end
      CHURN: begin
        if      (r < 14) c = CMD_ALLOC;
        else if (r < 26) c = CMD_ALLOC_LINK;
        else if (r < 40) c = CMD_RELEASE;
        else if (r < 54) c = CMD_LINK;
        else if (r < 62) c = CMD_UNLINK;
        else if (r < 78) c = CMD_FIND;
        else if (r < 96) c = CMD_RELEASE_TAG;
        else             c = CMD_UNUSED;
      end
      default: begin
        if      (r < 8)  c = CMD_ALLOC;
        else if (r < 12) c = CMD_ALLOC_LINK;
        else if (r < 52) c = CMD_RELEASE;
        else if (r < 62) c = CMD_LINK;
        else if (r < 67) c = CMD_UNLINK;
        else if (r < 77) c = CMD_FIND;
        else if (r < 98) c = CMD_RELEASE_TAG;
        else             c = CMD_UNUSED;
      end
    endcase
    // Low slots are handed out first, so they are in use more often.
    idx = $urandom_range(1) ? $urandom_range(15) : $urandom_range(NUM_SLOTS - 1);
    // A small set of live tags makes finds hit and gives several matches.
    case ($urandom_range(9))
      0, 1:    tag = $urandom_range(16'hFFFF);
      2:       tag = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: tag = hot_tags[$urandom_range(5)];
    endcase
  endtask

  // The receiver stalls in segments of random duty, with a long hold-off now
  // and then so that the block backs up and stalls its input.
  initial begin
    int seg_no;
    int seg_len;
    int duty;
    out_stall = 1'b0;
    seg_no    = 0;
    forever begin
      seg_no++;
      if (seg_no % 12 == 3) begin
        seg_len = HOLDOFF_CYCLES;
        duty    = 100;
      end else begin
        seg_len = $urandom_range(20, 200);
        case ($urandom_range(3))
          0:       duty = 0;
          1:       duty = 25;
          2:       duty = 50;
          default: duty = 75;
        endcase
      end
      repeat (seg_len) begin
        @(negedge clk);
        out_stall = ($urandom_range(99) < duty);
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Run limit reached with %0d results still pending.", results_due);
    $display("slot_pool_allocator_with_tag_map_tb NOT OK");
    $finish;
  end

  initial begin
    traffic_mix_t     mix;
    int               phase_left;
    int               burst_len;
    int               next_pause;
    logic [CMD_W-1:0] c;
    int               idx;
    int               tag;

    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = '0;
    target_slot = '0;
    entity_tag  = '0;
    beats_sent  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: basic allocation, tag extremes, lowest-match find, and the
    // cases where a command must be ignored.
    send_beat(CMD_ALLOC,       0,  16'h0000);
    send_beat(CMD_ALLOC_LINK,  0,  16'hFFFF);
    send_beat(CMD_LINK,        0,  16'h0000);
    send_beat(CMD_FIND,        0,  16'h0000);
    send_beat(CMD_FIND,        0,  16'hFFFF);
    send_beat(CMD_FIND,        0,  16'h1234);
    send_beat(CMD_LINK,        63, 16'h5555);
    send_beat(CMD_UNLINK,      0,  16'h0000);
    send_beat(CMD_FIND,        0,  16'h0000);
    send_beat(CMD_RELEASE,     1,  16'h0000);
    send_beat(CMD_RELEASE,     1,  16'h0000);
    send_beat(CMD_RELEASE_TAG, 0,  16'hFFFF);
    send_beat(CMD_LINK,        0,  16'hAAAA);
    send_beat(CMD_ALLOC_LINK,  0,  16'hAAAA);
    send_beat(CMD_FIND,        0,  16'hAAAA);
    send_beat(CMD_RELEASE_TAG, 0,  16'hAAAA);
    send_beat(CMD_FIND,        0,  16'hAAAA);
    send_beat(CMD_UNUSED,      63, 16'hFFFF);
    send_beat(CMD_UNLINK,      5,  16'h0000);
    send_beat(CMD_RELEASE,     63, 16'h0000);
    send_beat(CMD_ALLOC,       0,  16'h0000);
    send_beat(CMD_FIND,        0,  16'hAAAA);
    wait_for_results();

    mix        = FILL_UP;
    phase_left = 0;
    next_pause = beats_sent + PAUSE_EVERY;
    while (beats_sent < RANDOM_ITEMS + 22) begin
      if (phase_left <= 0) begin
        case ($urandom_range(2))
          0:       mix = FILL_UP;
          1:       mix = CHURN;
          default: mix = DRAIN_DOWN;
        endcase
        phase_left = $urandom_range(60, 160);
        foreach (hot_tags[i]) hot_tags[i] = $urandom_range(16'hFFFF);
      end
      burst_len = ($urandom_range(4) == 0) ? 60 : $urandom_range(1, 24);
      repeat (burst_len) begin
        pick_command(mix, c, idx, tag);
        send_beat(c, idx, tag);
        phase_left--;
      end
      if (beats_sent >= next_pause) begin
        wait_for_results();
        next_pause = beats_sent + PAUSE_EVERY;
      end else begin
        idle_for($urandom_range(1, 8));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands; %0d results checked, %0d of them successful.",
             beats_sent, results_seen, ok_seen);
    $display("Pool occupancy peaked at %0d slots; allocation hit an empty pool %0d times.",
             peak_active, pool_empty_hits);
    if (fail_count == 0) begin
      $display("slot_pool_allocator_with_tag_map_tb OK");
    end else begin
      $display("slot_pool_allocator_with_tag_map_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/spat_pkg.sv
src/spat_free_stack.sv
src/spat_tag_scan.sv
src/slot_pool_allocator_with_tag_map.sv
verif/slot_pool_checker.sv
verif/slot_pool_allocator_with_tag_map_tb.sv
